>>> rtl/soc_pkg.sv
// Shared types and constants for the sensor offset calibrator.
package soc_pkg;

  localparam int MEAN_W  = 26;   // running mean, readings scaled by 1000
  localparam int OFF_W   = 16;   // finished offset
  localparam int DIV_W   = 34;   // dividend of the mean-update divider
  localparam int DVS_W   = 10;   // divisor of the mean-update divider
  localparam int UPC_W   = 5;    // microprogram address

  localparam logic [7:0]       ID_EXPECTED = 8'h68;
  localparam logic [DVS_W-1:0] SCALE       = 10'd1000;

  // mean/1000 as (|mean| * ceil(2^35/1000)) >> 35, exact for |mean| < 2^25
  localparam int               RCP_W     = 26;
  localparam int               RCP_SH    = 35;
  localparam logic [RCP_W-1:0] SCALE_RCP = 26'd34359739;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    ST_ID_OK     = 3'd0,
    ST_ID_BAD    = 3'd1,
    ST_SAMPLE    = 3'd2,
    ST_DONE      = 3'd3,
    ST_READ_ERR  = 3'd4,
    ST_NOT_ARMED = 3'd5
  } stat_t;

  // datapath operation selected by the control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_ID,
    ACT_NOTARM,
    ACT_RDERR,
    ACT_SCALE,
    ACT_SUM,
    ACT_DIV_MEAN,
    ACT_TAKE_MEAN,
    ACT_TAKE_X,
    ACT_SAMPLE,
    ACT_DIV_OFF,
    ACT_DONE,
    ACT_POST
  } act_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_GOTO,
    BR_IF,
    BR_HOLD
  } br_t;

  typedef enum logic [2:0] {
    CD_NO_ITEM,
    CD_IS_ID,
    CD_UNARMED,
    CD_READ_BAD,
    CD_FIRST,
    CD_NOT_FULL,
    CD_DIV_BUSY,
    CD_OUT_BUSY
  } cond_t;

  typedef struct packed {
    br_t   br;
    cond_t cnd;
    act_t  act;
    upc_t  tgt;
  } cword_t;

  // condition flags from datapath to sequencer
  typedef struct packed {
    logic no_item;
    logic is_id;
    logic unarmed;
    logic read_bad;
    logic first;
    logic not_full;
    logic div_busy;
    logic out_busy;
  } flags_t;

endpackage

>>> rtl/soc_ifs.sv
// Valid/ready channel interfaces for input items and result items.
interface soc_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] id_byte;
  logic [7:0] sample_high;
  logic [7:0] sample_low;
  logic       read_ok;

  modport source (output valid, func, id_byte, sample_high, sample_low, read_ok,
                  input ready);
  modport sink   (input valid, func, id_byte, sample_high, sample_low, read_ok,
                  output ready);
endinterface

interface soc_result_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          status;
  logic [2:0]                          channel;
  logic signed [soc_pkg::MEAN_W-1:0]   running_mean;
  logic signed [soc_pkg::OFF_W-1:0]    offset;

  modport source (output valid, status, channel, running_mean, offset, input ready);
  modport sink   (input valid, status, channel, running_mean, offset, output ready);
endinterface

>>> rtl/soc_div.sv
// Signed divider for the mean update, one quotient bit per cycle, truncating toward zero.
module soc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [soc_pkg::DIV_W-1:0]   dividend,
  input  logic [soc_pkg::DVS_W-1:0]          divisor,
  output logic                               busy,
  output logic signed [soc_pkg::DIV_W-1:0]   quotient
);
  import soc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             neg;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem, quo[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == LAST) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
      neg <= dividend[DIV_W-1];
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

>>> rtl/soc_useq.sv
// Microprogram store and step counter with conditional jumps.
module soc_useq (
  input  logic            clk,
  input  logic            rst,
  input  soc_pkg::flags_t flags,
  output soc_pkg::act_t   act
);
  import soc_pkg::*;

  // program labels
  localparam upc_t L_IDLE  = 5'd0;
  localparam upc_t L_FIRST = 5'd9;
  localparam upc_t L_CHK   = 5'd10;
  localparam upc_t L_SMP   = 5'd14;
  localparam upc_t L_ID    = 5'd15;
  localparam upc_t L_NA    = 5'd16;
  localparam upc_t L_RE    = 5'd17;
  localparam upc_t L_POST  = 5'd18;

  upc_t   upc;
  upc_t   upc_next;
  cword_t cw;
  logic   c;

  always_comb begin
    case (upc)
      5'd0:  cw = '{BR_HOLD, CD_NO_ITEM,  ACT_ACCEPT,    L_IDLE};
      5'd1:  cw = '{BR_IF,   CD_IS_ID,    ACT_NONE,      L_ID};
      5'd2:  cw = '{BR_IF,   CD_UNARMED,  ACT_NONE,      L_NA};
      5'd3:  cw = '{BR_IF,   CD_READ_BAD, ACT_NONE,      L_RE};
      5'd4:  cw = '{BR_IF,   CD_FIRST,    ACT_SCALE,     L_FIRST};
      5'd5:  cw = '{BR_NEXT, CD_FIRST,    ACT_SUM,       L_IDLE};
      5'd6:  cw = '{BR_NEXT, CD_FIRST,    ACT_DIV_MEAN,  L_IDLE};
      5'd7:  cw = '{BR_HOLD, CD_DIV_BUSY, ACT_NONE,      L_IDLE};
      5'd8:  cw = '{BR_GOTO, CD_FIRST,    ACT_TAKE_MEAN, L_CHK};
      5'd9:  cw = '{BR_NEXT, CD_FIRST,    ACT_TAKE_X,    L_IDLE};
      5'd10: cw = '{BR_IF,   CD_NOT_FULL, ACT_NONE,      L_SMP};
      5'd11: cw = '{BR_NEXT, CD_FIRST,    ACT_DIV_OFF,   L_IDLE};
      5'd12: cw = '{BR_HOLD, CD_DIV_BUSY, ACT_NONE,      L_IDLE};
      5'd13: cw = '{BR_GOTO, CD_FIRST,    ACT_DONE,      L_POST};
      5'd14: cw = '{BR_GOTO, CD_FIRST,    ACT_SAMPLE,    L_POST};
      5'd15: cw = '{BR_GOTO, CD_FIRST,    ACT_ID,        L_POST};
      5'd16: cw = '{BR_GOTO, CD_FIRST,    ACT_NOTARM,    L_POST};
      5'd17: cw = '{BR_GOTO, CD_FIRST,    ACT_RDERR,     L_POST};
      5'd18: cw = '{BR_HOLD, CD_OUT_BUSY, ACT_NONE,      L_IDLE};
      5'd19: cw = '{BR_GOTO, CD_FIRST,    ACT_POST,      L_IDLE};
      default: cw = '{BR_GOTO, CD_FIRST,  ACT_NONE,      L_IDLE};
    endcase
  end

  always_comb begin
    case (cw.cnd)
      CD_NO_ITEM:  c = flags.no_item;
      CD_IS_ID:    c = flags.is_id;
      CD_UNARMED:  c = flags.unarmed;
      CD_READ_BAD: c = flags.read_bad;
      CD_FIRST:    c = flags.first;
      CD_NOT_FULL: c = flags.not_full;
      CD_DIV_BUSY: c = flags.div_busy;
      CD_OUT_BUSY: c = flags.out_busy;
      default:     c = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.br)
      BR_NEXT: upc_next = upc + 1'b1;
      BR_GOTO: upc_next = cw.tgt;
      BR_IF:   upc_next = c ? cw.tgt : upc + 1'b1;
      BR_HOLD: upc_next = c ? upc : upc + 1'b1;
      default: upc_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= L_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign act = cw.act;

endmodule

>>> rtl/sensor_offset_calibrator_unit.sv
// Top level: sensor offset calibrator datapath around a microcoded sequencer.
//
//  channel  role    carries                                         transfer when
//  item     sink    func, id_byte, sample_high, sample_low, read_ok valid && ready
//  result   source  status, channel, running_mean, offset           valid && ready
//
// One item at a time. Later samples wait on the 34-step divider for the mean update; the
// last sample of a channel also computes mean/1000 by reciprocal multiply. rst (synchronous)
// returns the sequencer to its wait step and clears channel, count, mean and armed;
// ready stays low during reset. A stalled result holds in the output register; the
// next item is still taken, and its result waits for the transfer.
module sensor_offset_calibrator_unit #(
  parameter int SAMPLES_PER_CHANNEL = 64,
  parameter int CHANNELS            = 7
) (
  input logic          clk,
  input logic          rst,
  soc_item_if.sink     item,
  soc_result_if.source result
);
  import soc_pkg::*;

  // calibration state
  logic [2:0]               current_channel;
  logic [7:0]               sample_count;
  logic signed [MEAN_W-1:0] mean_acc;
  logic                     armed;

  // captured item
  logic                     func_r;
  logic [7:0]               id_r;
  logic signed [15:0]       smp_r;
  logic                     ok_r;
  logic [2:0]               chan_r;

  // arithmetic pipeline
  logic signed [MEAN_W-1:0] x_r;
  logic signed [DIV_W-1:0]  prod_r;
  logic signed [DIV_W-1:0]  sum_r;
  logic signed [MEAN_W:0]   x_full;
  logic signed [DIV_W:0]    prod_full;

  // offset = mean/1000 by reciprocal multiplication
  logic [MEAN_W-1:0]        off_mag_in;
  logic [MEAN_W+RCP_W-1:0]  off_prod;
  logic [OFF_W-1:0]         off_mag_r;
  logic                     off_neg_r;

  // pending result
  stat_t                    res_status;
  logic signed [MEAN_W-1:0] res_mean;
  logic signed [OFF_W-1:0]  res_offset;

  logic                     out_valid;

  act_t                     act;
  flags_t                   flags;

  logic                     div_start;
  logic                     div_busy;
  logic signed [DIV_W-1:0]  div_dividend;
  logic [DVS_W-1:0]         div_divisor;
  logic signed [DIV_W-1:0]  div_quo;

  logic [3:0]               chan_inc;

  soc_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .act   (act)
  );

  soc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign item.ready = (act == ACT_ACCEPT) && !rst;

  always_comb begin
    flags.no_item  = !item.valid;
    flags.is_id    = !func_r;
    flags.unarmed  = !armed;
    flags.read_bad = !ok_r;
    flags.first    = (sample_count == 8'd0);
    flags.not_full = (sample_count < 8'(SAMPLES_PER_CHANNEL));
    flags.div_busy = div_busy;
    flags.out_busy = out_valid;
  end

  // reading * 1000 and mean * n, each registered before the sum
  assign x_full    = smp_r * $signed({1'b0, SCALE});
  assign prod_full = mean_acc * $signed({1'b0, sample_count});

  // divider only serves the mean update: (mean*n + x) / (n+1)
  assign div_start    = (act == ACT_DIV_MEAN);
  assign div_dividend = sum_r;
  assign div_divisor  = DVS_W'(sample_count) + DVS_W'(1);

  // |mean| * reciprocal; quotient sits at bit RCP_SH and above
  assign off_mag_in = mean_acc[MEAN_W-1] ? MEAN_W'(-mean_acc) : MEAN_W'(mean_acc);
  assign off_prod   = off_mag_in * SCALE_RCP;

  assign chan_inc = {1'b0, current_channel} + 4'd1;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_channel <= '0;
      sample_count    <= '0;
      mean_acc        <= '0;
      armed           <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (act)
        ACT_ID: begin
          sample_count <= '0;
          mean_acc     <= '0;
          armed        <= ok_r && (id_r == ID_EXPECTED);
        end
        ACT_RDERR: begin
          sample_count <= '0;
          mean_acc     <= '0;
          armed        <= 1'b0;
        end
        ACT_TAKE_MEAN: begin
          mean_acc     <= div_quo[MEAN_W-1:0];
          sample_count <= sample_count + 8'd1;
        end
        ACT_TAKE_X: begin
          mean_acc     <= x_r;
          sample_count <= sample_count + 8'd1;
        end
        ACT_DONE: begin
          sample_count    <= '0;
          mean_acc        <= '0;
          armed           <= 1'b0;
          current_channel <= (chan_inc >= 4'(CHANNELS)) ? 3'd0 : chan_inc[2:0];
        end
        ACT_POST: begin
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (act)
      ACT_ACCEPT: begin
        if (item.valid) begin
          func_r <= item.func;
          id_r   <= item.id_byte;
          smp_r  <= $signed({item.sample_high, item.sample_low});
          ok_r   <= item.read_ok;
          chan_r <= current_channel;
        end
      end
      ACT_ID: begin
        res_status <= (ok_r && (id_r == ID_EXPECTED)) ? ST_ID_OK : ST_ID_BAD;
        res_mean   <= '0;
        res_offset <= '0;
      end
      ACT_NOTARM: begin
        res_status <= ST_NOT_ARMED;
        res_mean   <= mean_acc;
        res_offset <= '0;
      end
      ACT_RDERR: begin
        res_status <= ST_READ_ERR;
        res_mean   <= '0;
        res_offset <= '0;
      end
      ACT_SCALE: begin
        x_r    <= x_full[MEAN_W-1:0];
        prod_r <= prod_full[DIV_W-1:0];
      end
      ACT_SUM: begin
        sum_r <= prod_r + DIV_W'(x_r);
      end
      ACT_SAMPLE: begin
        res_status <= ST_SAMPLE;
        res_mean   <= mean_acc;
        res_offset <= '0;
      end
      ACT_DIV_OFF: begin
        off_mag_r <= off_prod[RCP_SH +: OFF_W];
        off_neg_r <= mean_acc[MEAN_W-1];
      end
      ACT_DONE: begin
        res_status <= ST_DONE;
        res_mean   <= mean_acc;
        res_offset <= off_neg_r ? -$signed(off_mag_r) : $signed(off_mag_r);
      end
      ACT_POST: begin
        result.status       <= res_status;
        result.channel      <= chan_r;
        result.running_mean <= res_mean;
        result.offset       <= res_offset;
      end
      default: begin
      end
    endcase
  end

  assign result.valid = out_valid;

endmodule
